// ===== hdl/dspm_pkg.sv =====
package dspm_pkg;

    // Largest pattern the core is built for by default.
    localparam int MAX_ELEMENTS_DEFAULT = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STAR_MASK  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 2'd3;

    localparam int LENGTH_REG_W = 5;

    // Pattern byte that matches any subject byte ('.').
    localparam logic [7:0] ANY_BYTE = 8'h2E;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic close;   // epsilon step from a live starred position (current set)
        logic move;    // a plain element consumed the byte and advances
        logic nclose;  // epsilon step from a live starred position (next set)
        logic active;  // the sending position lies inside the pattern
    } link_t;

endpackage

// ===== hdl/dot_star_pattern_matcher_core.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------
// s_        | in        | s_valid / s_ready  | s_ch, s_is_last, s_no_char
// m_        | out       | m_valid / m_ready  | m_matched, m_string_done
// cfg_      | in        | cfg_wr_en only     | cfg_index, cfg_wdata
//
// One request is taken per cycle when not stalled; its verdict appears on the m_
// side in the cycle after acceptance, set by the update of the row of position cells.
// Reset (aresetn low at a clock edge) clears the pattern registers and leaves
// only position zero live; no clearing pass is needed.
// The input stalls only while a verdict waits in the output register under a
// low m_ready; a verdict being taken frees the slot in the same cycle.
module dot_star_pattern_matcher_core #(
    parameter int MAX_ELEMENTS = dspm_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Subject string, one byte per request.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_ch,
    input  logic                              s_is_last,
    input  logic                              s_no_char,
    // Verdict per request.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_matched,
    output logic                              m_string_done,
    // Pattern configuration.
    input  logic                              cfg_wr_en,
    input  logic [dspm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dspm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dspm_pkg::*;

    // Width of a length that may reach MAX_ELEMENTS, also the select width
    // over the MAX_ELEMENTS+1 pattern positions.
    localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

    // ------------------------------------------------------------------
    // Configuration registers. They take effect on the very next request,
    // also in the middle of a string; live bits above a shorter length are
    // masked off by the cells.
    // ------------------------------------------------------------------
    logic [63:0]             pattern_chars_low_reg;
    logic [63:0]             pattern_chars_high_reg;
    logic [15:0]             star_mask_reg;
    logic [LENGTH_REG_W-1:0] pattern_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_chars_low_reg  <= '0;
            pattern_chars_high_reg <= '0;
            star_mask_reg          <= '0;
            pattern_length_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHARS_LOW:  pattern_chars_low_reg  <= cfg_wdata[63:0];
                CFG_CHARS_HIGH: pattern_chars_high_reg <= cfg_wdata[63:0];
                CFG_STAR_MASK:  star_mask_reg          <= cfg_wdata[15:0];
                CFG_LENGTH:     pattern_length_reg     <= cfg_wdata[LENGTH_REG_W-1:0];
            endcase
        end
    end

    // A programmed length above what the core was built for is clamped.
    logic [LEN_W-1:0] len_act;
    always_comb begin
        if (pattern_length_reg > LENGTH_REG_W'(MAX_ELEMENTS)) begin
            len_act = LEN_W'(MAX_ELEMENTS);
        end else begin
            len_act = LEN_W'(pattern_length_reg);
        end
    end

    logic [127:0] pattern_chars;
    assign pattern_chars = {pattern_chars_high_reg, pattern_chars_low_reg};

    // ------------------------------------------------------------------
    // Handshake. The output register parts the two sides: a new request is
    // taken whenever the slot is empty or is being emptied this cycle.
    // ------------------------------------------------------------------
    logic accept;
    logic m_valid_reg;
    logic m_valid_next;
    logic m_matched_reg;
    logic m_matched_next;
    logic m_string_done_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Row of position cells. Cell i owns live bit i and pattern element i.
    // Each cell closes the current set over a starred element, tests the
    // incoming byte, and closes the next set, handing the carries to its
    // right-hand neighbor. The final position (pattern fully consumed) has
    // no element and is kept here.
    // ------------------------------------------------------------------
    link_t                 links [0:MAX_ELEMENTS];
    logic [MAX_ELEMENTS:0] pos_vec;
    logic [MAX_ELEMENTS:0] live_vec;
    logic [MAX_ELEMENTS:0] range_vec;

    assign links[0] = '{close: 1'b0, move: 1'b0, nclose: 1'b0, active: 1'b1};
    assign range_vec[0] = 1'b1;

    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        dspm_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .len     (len_act),
            .elem    (pattern_chars[8*i +: 8]),
            .star    (star_mask_reg[i]),
            .ch      (s_ch),
            .no_char (s_no_char),
            .accept  (accept),
            .last    (s_is_last),
            .left    (links[i]),
            .right   (links[i+1]),
            .live_q  (live_vec[i]),
            .pos_now (pos_vec[i])
        );
        assign range_vec[i+1] = links[i+1].active;
    end

    // End position: reached by a plain element consuming the byte, or by an
    // epsilon step over a starred last element.
    logic end_live_reg;
    logic end_live_next;
    logic end_cur;
    logic end_adv;

    assign end_cur = (end_live_reg & links[MAX_ELEMENTS].active) | links[MAX_ELEMENTS].close;
    assign end_adv = s_no_char ? end_cur : links[MAX_ELEMENTS].move;
    assign pos_vec[MAX_ELEMENTS]  = end_adv | links[MAX_ELEMENTS].nclose;
    assign live_vec[MAX_ELEMENTS] = end_live_reg;

    always_comb begin
        end_live_next = end_live_reg;
        if (accept) begin
            // After the last byte of a string the set starts over.
            end_live_next = s_is_last ? 1'b0 : pos_vec[MAX_ELEMENTS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_live_reg <= 1'b0;
        end else begin
            end_live_reg <= end_live_next;
        end
    end

    // ------------------------------------------------------------------
    // Verdict: the string matches when the position at the pattern length
    // is live in the updated set.
    // ------------------------------------------------------------------
    assign m_matched_next = pos_vec[len_act];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_matched_reg     <= m_matched_next;
            m_string_done_reg <= s_is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_matched     = m_matched_reg;
    assign m_string_done = m_string_done_reg;

`ifndef NO_ASSERTIONS
    // The end of a string leaves only position zero live.
    a_restart_after_last : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_is_last |=> live_vec == (MAX_ELEMENTS+1)'(1))
        else $error("live set not restarted after the last byte");

    // Every accepted request produces a verdict in the output register.
    a_verdict_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request left no verdict");

    // An update never leaves positions beyond the pattern length live.
    a_live_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (live_vec & ~$past(range_vec)) == '0)
        else $error("live bit beyond pattern length");

    // The verdict sits in a fixed register while the consumer stalls, so a
    // stalled slot never takes a new request.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !accept)
        else $error("request accepted over a pending verdict");
`endif

endmodule

// ===== hdl/dspm_cell.sv =====
module dspm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LEN_W-1:0] len,
    input  logic [7:0]       elem,
    input  logic             star,
    input  logic [7:0]       ch,
    input  logic             no_char,
    input  logic             accept,
    input  logic             last,
    input  dspm_pkg::link_t  left,
    output dspm_pkg::link_t  right,
    output logic             live_q,
    output logic             pos_now
);
    import dspm_pkg::*;

    localparam logic LIVE_INIT = (IDX == 0) ? 1'b1 : 1'b0;

    logic live_reg;
    logic live_next;
    logic active;
    logic in_range;
    logic cur;
    logic hit;
    logic adv;
    logic pos;

    // A position is inside the set when it is at most the pattern length,
    // which is exactly when the left neighbor is an element in use.
    assign active   = (LEN_W'(IDX) < len);
    assign in_range = left.active;

    // Closed current set, consumed byte, then closed next set.
    assign cur = (live_reg & in_range) | left.close;
    assign hit = cur & active & ((elem == ANY_BYTE) || (elem == ch));
    assign adv = no_char ? cur : ((hit & star) | left.move);
    assign pos = adv | left.nclose;

    assign right.close  = cur & star & active;
    assign right.move   = hit & ~star;
    assign right.nclose = pos & star & active;
    assign right.active = active;

    always_comb begin
        live_next = live_reg;
        if (accept) begin
            live_next = last ? LIVE_INIT : pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= LIVE_INIT;
        end else begin
            live_reg <= live_next;
        end
    end

    assign live_q  = live_reg;
    assign pos_now = pos;

endmodule

// ===== tb/sv/tb_dot_star_pattern_matcher_core.sv =====
`timescale 1ns / 1ps

module tb_dot_star_pattern_matcher_core;

    import dspm_pkg::*;

    // The core is built for its largest pattern; the expected verdicts use the same bound.
    localparam int PAT_MAX = MAX_ELEMENTS_DEFAULT;

    // One subject request as the sender offers it, and one verdict as the receiver sees it.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       no_byte;
    } subject_req_t;

    typedef struct packed {
        logic matched;
        logic done;
    } verdict_t;

    // Every input of the core has a known value from time zero on.
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_ch          = '0;
    logic                   s_is_last     = 1'b0;
    logic                   s_no_char     = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_matched;
    logic                   m_string_done;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    // Requests waiting for the driver, and verdicts that the core still owes us.
    subject_req_t subject_bytes[$];
    verdict_t     verdicts_due[$];

    // Our own copy of the pattern registers and of the live position set.
    logic [127:0] pat_chars = '0;
    logic [15:0]  pat_star  = '0;
    logic [4:0]   pat_len   = '0;
    logic [16:0]  live_set  = 17'd1;

    // Scratch buffer in which a subject string is spelled before it is queued.
    logic [7:0]   spelling[$];

    logic s_took        = 1'b0;  // request accepted at the last rising edge
    logic calm          = 1'b0;  // no idling on either side once set
    int   src_gap       = 0;
    int   sink_gap      = 0;
    int   hold_left     = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   queued_reqs   = 0;
    int   mismatches    = 0;

    always #5 aclk = ~aclk;

    dot_star_pattern_matcher_core #(
        .MAX_ELEMENTS(PAT_MAX)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_is_last    (s_is_last),
        .s_no_char    (s_no_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched),
        .m_string_done(m_string_done),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------------

    // A length register above the build size behaves as the build size.
    function automatic int unsigned active_len();
        return (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
    endfunction

    // Drop positions beyond the pattern end, then let every live starred
    // position also enable its successor. Walking upward makes chains of
    // starred elements close in a single pass.
    function automatic logic [16:0] close_live(input logic [16:0] set, input int unsigned n);
        logic [31:0] keep;
        logic [16:0] r;
        int          i;
        keep = (32'd1 << (n + 1)) - 32'd1;
        r    = set & keep[16:0];
        for (i = 0; i < n; i++) begin
            if (r[i] && pat_star[i]) begin
                r[i + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    // One subject byte moves the live set forward. A starred element that
    // matches keeps its own position alive, a plain one hands on to the next.
    // A request without a byte only closes the set over the starred elements.
    function automatic logic [16:0] advance_live(input logic [16:0] set, input logic [7:0] c,
                                                 input logic no_byte);
        int unsigned n;
        logic [16:0] cur;
        logic [16:0] nxt;
        logic [7:0]  e;
        int          i;
        n   = active_len();
        cur = close_live(set, n);
        if (no_byte) begin
            return cur;
        end
        nxt = '0;
        for (i = 0; i < n; i++) begin
            e = pat_chars[i*8 +: 8];
            if (cur[i] && (e == ANY_BYTE || e == c)) begin
                if (pat_star[i]) begin
                    nxt[i] = 1'b1;
                end else begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        return close_live(nxt, n);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued requests at the falling edge. A request stays on
    // the bus until the rising edge that takes it. Between requests the sender
    // may go quiet for a random burst.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        subject_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (!calm && subject_bytes.size() > 0 && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 3);
                s_valid <= 1'b0;
            end else if (subject_bytes.size() > 0) begin
                req = subject_bytes.pop_front();
                s_valid   <= 1'b1;
                s_ch      <= req.ch;
                s_is_last <= req.last;
                s_no_char <= req.no_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: normally ready, with random stall bursts. A long hold-off,
    // asked for by the stimulus, keeps m_ready low long enough
    // that the core's output slot fills and s_ready has to drop.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = 299;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at every rising edge an accepted request is turned into its
    // expected verdict, and a delivered verdict is checked against the oldest
    // one still owed.
    // ------------------------------------------------------------------------
    task automatic report_verdict(input string what, input verdict_t want, input verdict_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: verdict error, %s: expected matched=%0b done=%0b, got matched=%0b done=%0b",
                     $realtime, what, want.matched, want.done, got.matched, got.done);
        end
    endtask

    always @(posedge aclk) begin
        logic [16:0] next_set;
        verdict_t    want;
        verdict_t    got;
        s_took = aresetn && s_valid && s_ready;
        if (!aresetn) begin
            live_set = 17'd1;
        end else begin
            if (s_took) begin
                next_set     = advance_live(live_set, s_ch, s_no_char);
                want.matched = next_set[active_len()];
                want.done    = s_is_last;
                verdicts_due.insert(verdicts_due.size(), want);
                // The end of a string puts the matcher back at its start.
                live_set = s_is_last ? 17'd1 : next_set;
            end
            if (m_valid && m_ready) begin
                got.matched = m_matched;
                got.done    = m_string_done;
                if (verdicts_due.size() == 0) begin
                    report_verdict("no request outstanding", '0, got);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.matched !== want.matched || got.done !== want.done) begin
                        report_verdict("field differs", want, got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Register writes happen only while the core is idle, so our copy of the
    // registers can change at once. The task ends on a rising edge so that
    // whatever the caller queues next is never raced by the driver.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CHARS_LOW:  pat_chars[63:0]   = val;
            CFG_CHARS_HIGH: pat_chars[127:64] = val;
            CFG_STAR_MASK:  pat_star          = val[15:0];
            CFG_LENGTH:     pat_len           = val[4:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every queued request has been taken and every verdict has
    // arrived, then lets the clock run on past the output stage before it returns.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (subject_bytes.size() != 0 || s_valid || verdicts_due.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic push_req(input logic [7:0] c, input logic last, input logic no_byte);
        subject_req_t req;
        req.ch      = c;
        req.last    = last;
        req.no_byte = no_byte;
        subject_bytes.insert(subject_bytes.size(), req);
        queued_reqs++;
    endtask

    // Queues a short literal string, first byte in the most significant used
    // position, with the final byte marked as the end of the string.
    task automatic push_bytes(input logic [63:0] text, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) begin
            push_req(text[i*8 +: 8], i == 0, 1'b0);
        end
    endtask

    // Subject bytes lean toward the pattern alphabet so that matches are common,
    // but half of them range over every byte value.
    function automatic logic [7:0] random_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = "a";
            1: c = "b";
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = "a";
            3, 4, 5: c = "b";
            6, 7:    c = ANY_BYTE;
            8:       c = "*";
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Sends the spelled string. An empty string becomes a single end marker
    // without a byte. Now and then a request without a byte is slipped in, or
    // the end is marked by such a request instead of by the last byte.
    task automatic send_spelling();
        int  i;
        bit  end_apart;
        if (spelling.size() == 0) begin
            push_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            return;
        end
        end_apart = ($urandom_range(0, 9) == 0);
        for (i = 0; i < spelling.size(); i++) begin
            if ($urandom_range(0, 15) == 0) begin
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            push_req(spelling[i], !end_apart && i == spelling.size() - 1, 1'b0);
        end
        if (end_apart) begin
            push_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
        spelling.delete();
    endtask

    // Spells a string that the current pattern accepts, optionally damaged by
    // one changed, dropped or extra byte.
    task automatic push_conforming(input bit garble);
        int         i;
        int         k;
        int         reps;
        logic [7:0] e;
        for (i = 0; i < active_len(); i++) begin
            e    = pat_chars[i*8 +: 8];
            reps = pat_star[i] ? $urandom_range(0, 3) : 1;
            for (k = 0; k < reps; k++) begin
                spelling.insert(spelling.size(), (e == ANY_BYTE) ? random_byte() : e);
            end
        end
        if (garble) begin
            case ($urandom_range(0, 2))
                0: if (spelling.size() > 0) begin
                    spelling[$urandom_range(0, spelling.size() - 1)] = random_byte();
                end
                1: if (spelling.size() > 0) begin
                    void'(spelling.pop_back());
                end
                default: spelling.insert(spelling.size(), random_byte());
            endcase
        end
        send_spelling();
    endtask

    task automatic push_noise();
        int i;
        int n;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            spelling.insert(spelling.size(), random_byte());
        end
        send_spelling();
    endtask

    // Chooses a fresh pattern. Most are short patterns over a small alphabet;
    // some use random bytes, empty or full star masks, or the length extremes.
    // Upper bits of the mask and length writes carry junk that must be ignored.
    task automatic pick_pattern();
        logic [127:0] chars;
        logic [15:0]  mask;
        logic [4:0]   len;
        logic [63:0]  junk;
        int           i;
        int           mode;
        mode = $urandom_range(0, 9);
        for (i = 0; i < 16; i++) begin
            chars[i*8 +: 8] = pattern_byte();
        end
        if (mode == 0) begin
            chars = {$urandom, $urandom, $urandom, $urandom};
        end
        mask = 16'($urandom_range(0, 65535));
        if (mode == 1) begin
            mask = '0;
        end else if (mode == 2) begin
            mask = '1;
        end
        case ($urandom_range(0, 7))
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 12));
        endcase
        junk = {$urandom, $urandom};
        write_reg(CFG_CHARS_LOW, chars[63:0]);
        write_reg(CFG_CHARS_HIGH, chars[127:64]);
        write_reg(CFG_STAR_MASK, {junk[63:16], mask});
        write_reg(CFG_LENGTH, {junk[63:5], len});
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int target;
        int pick;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset pattern of length zero only the empty string matches.
        push_req(8'h00, 1'b1, 1'b1);
        push_bytes(64'h78, 1);
        push_bytes(64'hFF, 1);
        wait_drained();

        // Pattern a* . '*' b* 0xFF: a wildcard, a literal star byte, two
        // starred elements and a top-value byte.
        write_reg(CFG_CHARS_LOW, 64'h0000_00FF_622A_2E61);
        write_reg(CFG_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STAR_MASK, 64'h0009);
        write_reg(CFG_LENGTH, 64'd5);
        push_req(8'h00, 1'b1, 1'b1);
        push_bytes(64'h2E_2A_FF, 3);
        push_bytes(64'h6161_782A_62FF, 6);
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'h5A, 1'b0, 1'b1);
        push_bytes(64'h2A_FF, 2);

        // Leave a string open, change the star mask underneath it, then end it
        // with a request that carries no byte.
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'h41, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_STAR_MASK, 64'h0004);
        push_req(8'h2A, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);
        wait_drained();

        // A length beyond the build size is clipped: sixteen starred wildcards.
        write_reg(CFG_CHARS_LOW, {8{ANY_BYTE}});
        write_reg(CFG_CHARS_HIGH, {8{ANY_BYTE}});
        write_reg(CFG_STAR_MASK, 64'hFFFF);
        write_reg(CFG_LENGTH, 64'd31);
        push_req(8'h00, 1'b1, 1'b1);
        push_bytes(64'h00_FF, 2);
        wait_drained();

        // Random phases, each under a fresh pattern. Every phase ends with the
        // sender holding back until all verdicts are in. In the second phase
        // the receiver takes its long hold-off while requests keep coming, and
        // the final stretch runs with no idling on either side.
        phase = 0;
        while (queued_reqs < 1225) begin
            pick_pattern();
            if (queued_reqs >= 1025) begin
                calm = 1'b1;
            end
            target = queued_reqs + $urandom_range(60, 120);
            while (queued_reqs < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    push_conforming(pick >= 5);
                end else if (pick < 9) begin
                    push_noise();
                end else begin
                    push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end
            end
            if (phase == 1) begin
                hold_requests++;
            end
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        mismatches += verdicts_due.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Safety net: a correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
